// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every edge outside reset.
`define HPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next one.
`define HPT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ----- hw/rtl/hpt_pkg.sv -----
package hpt_pkg;
  localparam int FRAC_BITS = 16;
  // dividend width: 32-bit magnitude with the fraction shift appended
  localparam int DW = 32 + FRAC_BITS;
  // product after the fraction shift
  localparam int PW = 64 - FRAC_BITS;
  // sum of three products and one entry
  localparam int SW = PW + 2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_XFORM = 1'b1;

  localparam logic [31:0] ONE     = 32'(64'd1 << FRAC_BITS);
  localparam logic [31:0] POS_MAX = 32'h7fff_ffff;
  localparam logic [31:0] NEG_MIN = 32'h8000_0000;

  // everything that rides alongside the divider
  typedef struct packed {
    logic             dz;
    logic             sat;
    logic             bypass;
    logic [2:0]       neg;
    logic [2:0][31:0] s;
  } hpt_side_t;
endpackage

// ----- hw/rtl/hpt_div.sv -----
module hpt_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [2:0][hpt_pkg::DW-1:0]         in_num,
  input  logic [31:0]                         in_den,
  input  hpt_pkg::hpt_side_t                  in_side,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [2:0][hpt_pkg::DW-1:0]         out_quo,
  output hpt_pkg::hpt_side_t                  out_side
);
  import hpt_pkg::*;

  // one quotient bit per stage, restoring, three lanes sharing a divisor
  logic [DW:1]          vld;
  logic [DW+1:1]        rdy;
  logic [2:0][DW-1:0]   num  [1:DW];
  logic [2:0][31:0]     rem  [1:DW];
  logic [31:0]          den  [1:DW];
  hpt_side_t            side [1:DW];

  assign rdy[DW+1] = out_ready;
  assign in_ready  = rdy[1];

  for (genvar k = 1; k <= DW; k++) begin : g_stage
    logic               pv;
    logic [2:0][DW-1:0] pn;
    logic [2:0][31:0]   pr;
    logic [31:0]        pd;
    hpt_side_t          ps;
    logic [2:0][32:0]   sh;
    logic [2:0]         qb;
    logic [2:0][DW-1:0] num_next;
    logic [2:0][31:0]   rem_next;

    // previous stage, or the block inputs for the first one
    if (k == 1) begin : g_head
      assign pv = in_valid;
      assign pn = in_num;
      assign pr = '0;
      assign pd = in_den;
      assign ps = in_side;
    end else begin : g_body
      assign pv = vld[k-1];
      assign pn = num[k-1];
      assign pr = rem[k-1];
      assign pd = den[k-1];
      assign ps = side[k-1];
    end

    assign rdy[k] = !vld[k] || rdy[k+1];

    always_comb begin
      for (int j = 0; j < 3; j++) begin
        sh[j] = {pr[j], pn[j][DW-1]};
        qb[j] = (sh[j] >= {1'b0, pd});
        rem_next[j] = qb[j] ? 32'(sh[j] - {1'b0, pd}) : sh[j][31:0];
        num_next[j] = {pn[j][DW-2:0], qb[j]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        num[k]  <= num_next;
        rem[k]  <= rem_next;
        den[k]  <= pd;
        side[k] <= ps;
      end
    end
  end

  assign out_valid = vld[DW];
  assign out_quo   = num[DW];
  assign out_side  = side[DW];
endmodule

// ----- hw/rtl/homogeneous_point_transform.sv -----
// Pipeline: 3 front stages, 48 one-bit-per-stage divider stages and an output
//   register between input transfer and result; load items give no result.
// Throughput: one item per cycle while out_stall is low, set by the divider.
// Reset clears the matrix to zero and empties every pipeline stage.
module homogeneous_point_transform (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [1:0]  entry_row,
  input  logic [1:0]  entry_col,
  input  logic signed [31:0] entry_value,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic        divide_by_zero,
  output logic        saturated
);
  import hpt_pkg::*;

  logic signed [31:0] mat [4][4];
  logic signed [31:0] pt  [3];

  logic v1, v2, v3, ov;
  logic r1, r2, r3, rout;
  logic div_in_ready, div_out_valid;

  logic signed [PW-1:0] prod_next [3][4];
  logic signed [PW-1:0] prod [3][4];
  logic signed [31:0]   bias [4];
  logic signed [SW-1:0] sum [4];

  logic [3:0]          ovf;
  logic [3:0][31:0]    clamped;
  logic [2:0][31:0]    mag;
  logic [31:0]         wmag;
  hpt_side_t           side_next, side3, oside;
  logic [2:0][DW-1:0]  num3, quo;
  logic [31:0]         den3;

  logic [2:0]          qovf;
  logic [2:0][31:0]    qval, res;

  assign pt[0] = point_x;
  assign pt[1] = point_y;
  assign pt[2] = point_z;

  assign rout     = !ov || !out_stall;
  assign r3       = !v3 || div_in_ready;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign in_stall = !r1;

  // matrix loads take effect at transfer, so later points see them in order
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          mat[r][c] <= '0;
        end
      end
    end else if (in_valid && !in_stall && opcode == OP_LOAD) begin
      mat[entry_row][entry_col] <= entry_value;
    end
  end

  // stage 1: products, floor shift is an arithmetic right shift
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        prod_next[r][c] = PW'((64'(pt[r]) * 64'(mat[r][c])) >>> FRAC_BITS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid && opcode == OP_XFORM;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      prod <= prod_next;
      for (int c = 0; c < 4; c++) begin
        bias[c] <= mat[3][c];
      end
    end
  end

  // stage 2: column sums
  always_ff @(posedge clk) begin
    if (r2) begin
      for (int c = 0; c < 4; c++) begin
        sum[c] <= SW'(prod[0][c]) + SW'(prod[1][c]) + SW'(prod[2][c]) + SW'(bias[c]);
      end
    end
  end

  // stage 3: clamp, classify w, set up magnitudes for the divider
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      ovf[c] = !((&sum[c][SW-1:31]) || !(|sum[c][SW-1:31]));
      clamped[c] = ovf[c] ? (sum[c][SW-1] ? NEG_MIN : POS_MAX) : sum[c][31:0];
    end
    wmag = clamped[3][31] ? 32'(-clamped[3]) : clamped[3];
    for (int j = 0; j < 3; j++) begin
      mag[j]          = clamped[j][31] ? 32'(-clamped[j]) : clamped[j];
      side_next.s[j]  = clamped[j];
      side_next.neg[j] = clamped[j][31] ^ clamped[3][31];
    end
    side_next.dz     = (clamped[3] == '0);
    side_next.bypass = (clamped[3] == ONE);
    side_next.sat    = |ovf;
  end

  always_ff @(posedge clk) begin
    if (r3) begin
      side3 <= side_next;
      den3  <= wmag;
      for (int j = 0; j < 3; j++) begin
        num3[j] <= {mag[j], {FRAC_BITS{1'b0}}};
      end
    end
  end

  hpt_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .in_ready  (div_in_ready),
    .in_num    (num3),
    .in_den    (den3),
    .in_side   (side3),
    .out_valid (div_out_valid),
    .out_ready (rout),
    .out_quo   (quo),
    .out_side  (oside)
  );

  // sign and clamp the quotients, then pick the result
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (oside.neg[j]) begin
        qovf[j] = (|quo[j][DW-1:32]) || (quo[j][31] && (|quo[j][30:0]));
        qval[j] = qovf[j] ? NEG_MIN : 32'(-quo[j][31:0]);
      end else begin
        qovf[j] = (|quo[j][DW-1:32]) || quo[j][31];
        qval[j] = qovf[j] ? POS_MAX : quo[j][31:0];
      end
      if (oside.dz) begin
        res[j] = '0;
      end else if (oside.bypass) begin
        res[j] = oside.s[j];
      end else begin
        res[j] = qval[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (rout) begin
      ov <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rout) begin
      out_x          <= res[0];
      out_y          <= res[1];
      out_z          <= res[2];
      divide_by_zero <= oside.dz;
      saturated      <= oside.sat || (!oside.dz && !oside.bypass && (|qovf));
    end
  end

  assign out_valid = ov;
endmodule

// ----- hw/rtl/hpt_checker.sv -----
`include "assert_macros.svh"

module hpt_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_x,
  input logic [31:0] out_y,
  input logic [31:0] out_z,
  input logic        divide_by_zero,
  input logic        saturated
);
  `HPT_ASSERT_NEXT(a_hold_coords, out_valid && out_stall, out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z), "coordinates changed under stall")
  `HPT_ASSERT_NEXT(a_hold_flags, out_valid && out_stall, $stable(divide_by_zero) && $stable(saturated), "flags changed under stall")
  `HPT_ASSERT(a_dz_zero, !(out_valid && divide_by_zero) || (out_x == '0 && out_y == '0 && out_z == '0), "nonzero result on zero w")
  `HPT_ASSERT(a_reset_empty, !$past(rst) || !out_valid, "result right after reset")
endmodule

bind homogeneous_point_transform hpt_checker u_hpt_checker (.*);
